@@ src/rbes_pkg.sv @@
// Shared types, register codes and saturation helpers for the rigid body step.
// No dependencies.
`default_nettype none
package rbes_pkg;

  localparam int unsigned DivBits = 48;

  typedef enum logic [2:0] {
    RegGravity = 3'd0,
    RegMinX    = 3'd1,
    RegMaxX    = 3'd2,
    RegMinY    = 3'd3,
    RegMaxY    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] cap_x;
    logic [31:0] cap_y;
    logic        grav;
    logic [30:0] dt;
    logic        skip;
    logic        neg_x;
    logic        neg_y;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] quot_sat(input logic [DivBits-1:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (q > 48'd2147483647) ? 32'h7fff_ffff : q[31:0];
    end else begin
      r = (q > 48'd2147483648) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/rbes_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rbes_pkg.
`default_nettype none
module rbes_div
  import rbes_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [DivBits-1:0] dividend_i,
  input  wire logic [30:0]        divisor_i,
  output logic                    valid_o,
  output logic [DivBits-1:0]      quotient_o
);

  logic [DivBits-1:0] acc_q [DivBits];
  logic [DivBits-1:0] acc_d [DivBits];
  logic [30:0]        rem_q [DivBits];
  logic [30:0]        rem_d [DivBits];
  logic [30:0]        den_q [DivBits];
  logic [30:0]        den_d [DivBits];
  logic [DivBits-1:0] vld_q;
  logic [DivBits-1:0] vld_d;

  always_comb begin
    logic [DivBits-1:0] a;
    logic [30:0]        rm;
    logic [30:0]        dn;
    logic [31:0]        r;
    logic               ge;
    for (int k = 0; k < DivBits; k++) begin
      if (k == 0) begin
        a = dividend_i; rm = '0; dn = divisor_i; vld_d[k] = valid_i;
      end else begin
        a = acc_q[k-1]; rm = rem_q[k-1]; dn = den_q[k-1]; vld_d[k] = vld_q[k-1];
      end
      r  = {rm, a[DivBits-1]};
      ge = (r >= {1'b0, dn});
      rem_d[k] = ge ? 31'(r - {1'b0, dn}) : r[30:0];
      acc_d[k] = {a[DivBits-2:0], ge};
      den_d[k] = dn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivBits; k++) begin
      acc_q[k] <= acc_d[k];
      rem_q[k] <= rem_d[k];
      den_q[k] <= den_d[k];
    end
  end

  assign valid_o    = vld_q[DivBits-1];
  assign quotient_o = acc_q[DivBits-1];

endmodule
`default_nettype wire

@@ src/rigid_body_euler_step.sv @@
// Top level of the rigid body Euler step: input stage, two dividers, update stages.
// Depends on rbes_pkg and rbes_div.
//
// One body is taken in every cycle and never refused; busy stays low. Each result
// passes through the input stage, the 48-stage bit-per-stage dividers for force
// over mass and then the update stages of saturation, multiply, cap and wrap. The
// result is shown for one cycle with result_valid_o. Configuration writes are
// always ready and take effect on the next cycle.
`default_nettype none
module rigid_body_euler_step
  import rbes_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] vel_x_i,
  input  wire logic [31:0] vel_y_i,
  input  wire logic [31:0] force_x_i,
  input  wire logic [31:0] force_y_i,
  input  wire logic [30:0] body_mass_i,
  input  wire logic [31:0] vel_cap_x_i,
  input  wire logic [31:0] vel_cap_y_i,
  input  wire logic        gravity_on_i,
  input  wire logic [30:0] time_step_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [31:0]      new_pos_x_o,
  output logic [31:0]      new_pos_y_o,
  output logic [31:0]      new_vel_x_o,
  output logic [31:0]      new_vel_y_o,
  output logic [31:0]      accel_x_o,
  output logic [31:0]      accel_y_o,
  output logic             skipped_o
);

  logic signed [31:0] grav_q, min_x_q, max_x_q, min_y_q, max_y_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= '0; min_x_q <= '0; max_x_q <= '0; min_y_q <= '0; max_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegGravity: grav_q  <= cfg_data_i;
        RegMinX:    min_x_q <= cfg_data_i;
        RegMaxX:    max_x_q <= cfg_data_i;
        RegMinY:    min_y_q <= cfg_data_i;
        RegMaxY:    max_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  logic        s0_vld_q;
  logic [31:0] s0_mag_x_q, s0_mag_y_q;
  logic [30:0] s0_mass_q;
  side_t       s0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else         s0_vld_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    s0_mag_x_q <= force_x_i[31] ? (~force_x_i + 32'd1) : force_x_i;
    s0_mag_y_q <= force_y_i[31] ? (~force_y_i + 32'd1) : force_y_i;
    s0_mass_q  <= body_mass_i;
    s0_side_q  <= '{pos_x: pos_x_i, pos_y: pos_y_i, vel_x: vel_x_i, vel_y: vel_y_i,
                    cap_x: vel_cap_x_i, cap_y: vel_cap_y_i, grav: gravity_on_i,
                    dt: time_step_i, skip: (body_mass_i == '0),
                    neg_x: force_x_i[31], neg_y: force_y_i[31]};
  end

  logic               dx_vld, dy_vld;
  logic [DivBits-1:0] qx, qy;

  rbes_div u_div_x (
    .clk_i, .rst_ni, .valid_i(s0_vld_q), .dividend_i({s0_mag_x_q, 16'd0}),
    .divisor_i(s0_mass_q), .valid_o(dx_vld), .quotient_o(qx)
  );
  rbes_div u_div_y (
    .clk_i, .rst_ni, .valid_i(s0_vld_q), .dividend_i({s0_mag_y_q, 16'd0}),
    .divisor_i(s0_mass_q), .valid_o(dy_vld), .quotient_o(qy)
  );

  side_t side_line_q [DivBits];
  always_ff @(posedge clk_i) begin
    side_line_q[0] <= s0_side_q;
    for (int k = 1; k < DivBits; k++) side_line_q[k] <= side_line_q[k-1];
  end
  side_t sd;
  assign sd = side_line_q[DivBits-1];

  // update stages
  logic [8:0] vld_q;
  side_t      a_sd_q, g_sd_q, m1_sd_q, v1_sd_q, v2_sd_q, m2_sd_q, p1_sd_q, p2_sd_q;
  logic signed [31:0] a_ax_q, a_ay_q, g_ax_q, g_ay_q, m1_ax_q, m1_ay_q, v1_ax_q, v1_ay_q;
  logic signed [31:0] v2_ax_q, v2_ay_q, m2_ax_q, m2_ay_q, p1_ax_q, p1_ay_q, p2_ax_q, p2_ay_q;
  logic signed [63:0] m1_px_q, m1_py_q, m2_px_q, m2_py_q;
  logic signed [32:0] v1_sx_q, v1_sy_q, p1_sx_q, p1_sy_q;
  logic signed [31:0] v2_vx_q, v2_vy_q, m2_vx_q, m2_vy_q, p1_vx_q, p1_vy_q, p2_vx_q, p2_vy_q;
  logic signed [33:0] p2_wx_q, p2_wy_q;
  logic signed [31:0] g_ay_d, v2_vx_d, v2_vy_d, px_sat, py_sat;
  logic signed [33:0] p2_wx_d, p2_wy_d;

  always_comb begin
    logic signed [31:0] tx, ty;
    logic signed [32:0] wid_x, wid_y;
    g_ay_d = a_sd_q.grav
           ? sat32(64'(a_ay_q) + 64'(grav_q)) : a_ay_q;
    tx = sat32(64'(v1_sx_q));
    ty = sat32(64'(v1_sy_q));
    v2_vx_d = (tx < $signed(v1_sd_q.cap_x)) ? tx : $signed(v1_sd_q.cap_x);
    v2_vy_d = (ty < $signed(v1_sd_q.cap_y)) ? ty : $signed(v1_sd_q.cap_y);
    px_sat = sat32(64'(p1_sx_q));
    py_sat = sat32(64'(p1_sy_q));
    wid_x = 33'(max_x_q) - 33'(min_x_q);
    wid_y = 33'(max_y_q) - 33'(min_y_q);
    if (px_sat < min_x_q)      p2_wx_d = 34'(px_sat) + 34'(wid_x);
    else if (px_sat > max_x_q) p2_wx_d = 34'(px_sat) - 34'(wid_x);
    else                       p2_wx_d = 34'(px_sat);
    if (py_sat < min_y_q)      p2_wy_d = 34'(py_sat) + 34'(wid_y);
    else if (py_sat > max_y_q) p2_wy_d = 34'(py_sat) - 34'(wid_y);
    else                       p2_wy_d = 34'(py_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:0], dx_vld && dy_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    a_sd_q <= sd;
    a_ax_q <= quot_sat(qx, sd.neg_x);
    a_ay_q <= quot_sat(qy, sd.neg_y);
    g_sd_q <= a_sd_q; g_ax_q <= a_ax_q; g_ay_q <= g_ay_d;
    m1_sd_q <= g_sd_q; m1_ax_q <= g_ax_q; m1_ay_q <= g_ay_q;
    m1_px_q <= 64'(g_ax_q) * $signed({33'd0, g_sd_q.dt});
    m1_py_q <= 64'(g_ay_q) * $signed({33'd0, g_sd_q.dt});
    v1_sd_q <= m1_sd_q; v1_ax_q <= m1_ax_q; v1_ay_q <= m1_ay_q;
    v1_sx_q <= 33'($signed(sat32(m1_px_q >>> 16))) + 33'($signed(m1_sd_q.vel_x));
    v1_sy_q <= 33'($signed(sat32(m1_py_q >>> 16))) + 33'($signed(m1_sd_q.vel_y));
    v2_sd_q <= v1_sd_q; v2_ax_q <= v1_ax_q; v2_ay_q <= v1_ay_q;
    v2_vx_q <= v2_vx_d; v2_vy_q <= v2_vy_d;
    m2_sd_q <= v2_sd_q; m2_ax_q <= v2_ax_q; m2_ay_q <= v2_ay_q;
    m2_vx_q <= v2_vx_q; m2_vy_q <= v2_vy_q;
    m2_px_q <= 64'(v2_vx_q) * $signed({33'd0, v2_sd_q.dt});
    m2_py_q <= 64'(v2_vy_q) * $signed({33'd0, v2_sd_q.dt});
    p1_sd_q <= m2_sd_q; p1_ax_q <= m2_ax_q; p1_ay_q <= m2_ay_q;
    p1_vx_q <= m2_vx_q; p1_vy_q <= m2_vy_q;
    p1_sx_q <= 33'($signed(m2_sd_q.pos_x)) + 33'($signed(sat32(m2_px_q >>> 16)));
    p1_sy_q <= 33'($signed(m2_sd_q.pos_y)) + 33'($signed(sat32(m2_py_q >>> 16)));
    p2_sd_q <= p1_sd_q; p2_ax_q <= p1_ax_q; p2_ay_q <= p1_ay_q;
    p2_vx_q <= p1_vx_q; p2_vy_q <= p1_vy_q;
    p2_wx_q <= p2_wx_d; p2_wy_q <= p2_wy_d;
    if (p2_sd_q.skip) begin
      new_pos_x_o <= p2_sd_q.pos_x; new_pos_y_o <= p2_sd_q.pos_y;
      new_vel_x_o <= p2_sd_q.vel_x; new_vel_y_o <= p2_sd_q.vel_y;
      accel_x_o   <= '0;            accel_y_o   <= '0;
    end else begin
      new_pos_x_o <= sat32(64'(p2_wx_q)); new_pos_y_o <= sat32(64'(p2_wy_q));
      new_vel_x_o <= p2_vx_q;             new_vel_y_o <= p2_vy_q;
      accel_x_o   <= p2_ax_q;             accel_y_o   <= p2_ay_q;
    end
    skipped_o <= p2_sd_q.skip;
  end

  assign result_valid_o = vld_q[8];

  a_skip_zero_accel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && skipped_o |-> accel_x_o == '0 && accel_y_o == '0)
    else $error("skipped body carries nonzero acceleration");

  a_vel_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |=> $signed(p1_vx_q) <= $signed(p1_sd_q.cap_x)
              && $signed(p1_vy_q) <= $signed(p1_sd_q.cap_y))
    else $error("velocity above its cap");

  a_div_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx_vld == dy_vld)
    else $error("divider lanes out of step");

endmodule
`default_nettype wire
